// ----- src/line_point_generator_top_assert.svh -----
// Assertion macros for the checker file of the line point generator.
`ifndef LINE_POINT_GENERATOR_TOP_ASSERT_SVH
`define LINE_POINT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types for the line point generator: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lpg_pkg;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_DRAW = 1'b1
	} lpg_state_t;

	typedef struct packed {
		logic load;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic at_end;
	} dp_status_t;

endpackage

// ----- src/lpg_dp.sv -----
// ----------------------------------------------------------------------------
// lpg_dp
// Line datapath: holds the current point, target, deltas, directions and
// error term, steps one cell per push and registers the cell for output.
// ----------------------------------------------------------------------------
module lpg_dp #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpg_pkg::dp_cmd_t      cmd,
	output lpg_pkg::dp_status_t   status,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] cell_x,
	output logic [COORD_BITS-1:0] cell_y,
	output logic                  last
);
	import lpg_pkg::*;

	localparam int ErrW = COORD_BITS + 2;
	localparam int CmpW = COORD_BITS + 3;

	logic [COORD_BITS-1:0] point_x_q, point_y_q, target_x_q, target_y_q;
	logic [COORD_BITS-1:0] delta_x_q, delta_y_q;
	logic [ErrW-1:0]       err_q;
	logic                  step_x_neg_q, step_y_neg_q;
	logic [COORD_BITS-1:0] cell_x_q, cell_y_q;
	logic                  last_q;

	logic                  lt_x, lt_y;
	logic [COORD_BITS-1:0] dx_load, dy_load;
	logic [ErrW-1:0]       err_load;
	logic [CmpW-1:0]       e2, dx_cmp, neg_dy_cmp;
	logic                  take_x, take_y, at_end;
	logic [ErrW-1:0]       err_next;
	logic [COORD_BITS-1:0] point_x_next, point_y_next;

	always_comb begin
		lt_x     = start_x < end_x;
		lt_y     = start_y < end_y;
		dx_load  = lt_x ? end_x - start_x : start_x - end_x;
		dy_load  = lt_y ? end_y - start_y : start_y - end_y;
		err_load = {2'b00, dx_load} - {2'b00, dy_load};
	end

	always_comb begin
		at_end     = (point_x_q == target_x_q) && (point_y_q == target_y_q);
		e2         = {err_q, 1'b0};
		dx_cmp     = {3'b000, delta_x_q};
		neg_dy_cmp = CmpW'(0) - {3'b000, delta_y_q};
		take_x     = $signed(e2) > $signed(neg_dy_cmp);
		take_y     = $signed(e2) < $signed(dx_cmp);
		err_next   = err_q - (take_x ? {2'b00, delta_y_q} : ErrW'(0))
			+ (take_y ? {2'b00, delta_x_q} : ErrW'(0));
		point_x_next = point_x_q;
		point_y_next = point_y_q;
		if (take_x) begin
			point_x_next = step_x_neg_q ? point_x_q - COORD_BITS'(1)
				: point_x_q + COORD_BITS'(1);
		end
		if (take_y) begin
			point_y_next = step_y_neg_q ? point_y_q - COORD_BITS'(1)
				: point_y_q + COORD_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q    <= '0;
			point_y_q    <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			delta_x_q    <= '0;
			delta_y_q    <= '0;
			err_q        <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
		end else if (cmd.load) begin
			point_x_q    <= start_x;
			point_y_q    <= start_y;
			target_x_q   <= end_x;
			target_y_q   <= end_y;
			delta_x_q    <= dx_load;
			delta_y_q    <= dy_load;
			err_q        <= err_load;
			step_x_neg_q <= !lt_x;
			step_y_neg_q <= !lt_y;
		end else if (cmd.push && !at_end) begin
			point_x_q <= point_x_next;
			point_y_q <= point_y_next;
			err_q     <= err_next;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			cell_x_q <= point_x_q;
			cell_y_q <= point_y_q;
			last_q   <= at_end;
		end
	end

	assign status.at_end = at_end;
	assign cell_x        = cell_x_q;
	assign cell_y        = cell_y_q;
	assign last          = last_q;

endmodule

// ----- src/lpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpg_ctrl
// Line controller: takes a command word, walks the line one cell per free
// output slot and keeps the output word valid until it is taken.
// ----------------------------------------------------------------------------
module lpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output lpg_pkg::dp_cmd_t    cmd,
	input  lpg_pkg::dp_status_t status
);
	import lpg_pkg::*;

	lpg_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					cmd.push = 1'b1;
					if (status.at_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- src/line_point_generator_top.sv -----
// ----------------------------------------------------------------------------
// line_point_generator_top
// Bresenham line rasterizer: one command word in, one word per line cell out.
// ----------------------------------------------------------------------------
// Each command word gives a start and an end cell; the block emits every cell
// of the line from start to end, both included, in all octants, with tlast
// on the end cell. A line has N = max(|dx|,|dy|) + 1 cells. After the command
// is loaded, the single stepping datapath gives one cell per cycle while the
// output is not stalled; its error update and point step are combinational.
// The next command is taken as soon as the end cell sits in the output
// register, even while that word waits to be taken.
module line_point_generator_top #(
	parameter int COORD_BITS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, end_x, end_y, zero fill
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// cell_x, cell_y, zero fill
	output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
	output logic                                  m_tlast
);
	import lpg_pkg::*;

	localparam int OutW = ((2*COORD_BITS+7)/8)*8;

	dp_cmd_t               cmd;
	dp_status_t            status;
	logic [COORD_BITS-1:0] cell_x, cell_y;

	lpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	lpg_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.start_x (s_tdata[COORD_BITS-1:0]),
		.start_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.end_x   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.end_y   (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.cell_x  (cell_x),
		.cell_y  (cell_y),
		.last    (m_tlast)
	);

	assign m_tdata = OutW'({cell_y, cell_x});

endmodule

// ----- src/lpg_checker.sv -----
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks of the line point generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_point_generator_top_assert.svh"

module lpg_checker #(
	parameter int COORD_BITS = 6
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
	input logic                                m_tlast
);

	// hold a stalled output word
	`LPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")

	// drop ready right after a command is taken
	`LPG_ASSERT_NEXT(a_busy_after_load, s_tvalid && s_tready, !s_tready,
		"ready still high after a command word")

	// only the end cell may wait while a new command is open
	`LPG_ASSERT_NOW(a_idle_only_last, s_tready && m_tvalid, m_tlast,
		"ready high while a line is unfinished")

endmodule

bind line_point_generator_top lpg_checker #(
	.COORD_BITS (COORD_BITS)
) u_lpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
